>>> hdl/tggr_pkg.sv
// ----------------------------------------------------------------------------
// tggr_pkg
// Shared types, command codes and constants for the tactile gated grasp ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package tggr_pkg;

    localparam int NUM_JOINTS_DEF = 7;

    localparam logic [23:0] INVALID_PRESSURE = 24'd30000;
    localparam logic [31:0] THRESH_RESET     = 32'd10000000;
    localparam logic [3:0]  THUMB_LAST_SLOT  = 4'd1;
    localparam logic [3:0]  FINGER_LAST_SLOT = 4'd8;

    // step = round(|span| / 20) as (|span| + 10) * ceil(2^22 / 20) >> 22
    localparam logic [16:0] ROUND_BIAS  = 17'd10;
    localparam logic [17:0] STEP_RECIP  = 18'd209716;
    localparam int          STEP_SHIFT  = 22;
    localparam int          STEP_W      = 12;

    localparam logic [3:0] MODE_ACTIVE  = 4'h1;
    localparam logic [3:0] MODE_TIMEOUT = 4'h8;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_SAMPLE  = 3'd1,
        CMD_OPEN    = 3'd2,
        CMD_CLOSE   = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_RELEASE = 3'd5
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CALC,
        ST_STEP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         command;
        logic [3:0]         joint_index;
        logic signed [15:0] open_position;
        logic signed [15:0] closed_position;
        logic signed [15:0] start_position;
        logic signed [15:0] open_command_position;
        logic [3:0]         sensor_slot;
        logic [23:0]        pressure;
        logic               last_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         motor_id;
        logic [7:0]         mode_byte;
        logic signed [15:0] goal_position;
        logic               gains_enabled;
        logic               last_joint;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic accum;
        logic eval;
        logic set_closing;
        logic clr_closing;
        logic start_run;
        logic calc;
        logic step;
        logic next_joint;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic closing;
        logic both_gripped;
        logic last_joint;
        logic out_taken;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/tggr_ctrl.sv
// ----------------------------------------------------------------------------
// tggr_ctrl
// Sequencer: decodes accepted words and walks the joint runs one joint at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tggr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_command,
    input  wire logic               i_last_of_frame,
    input  wire tggr_pkg::t_dp_stat i_stat,
    output tggr_pkg::t_dp_cmd       o_cmd
);
    import tggr_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_command w_cmd_code;
    logic     w_accept;
    logic     w_tick_run;

    assign w_cmd_code = t_command'(i_command);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_tick_run = i_stat.closing && !i_stat.both_gripped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_cmd_code)
                        CMD_SAMPLE: begin
                            if (i_last_of_frame) n_state = ST_EVAL;
                        end
                        CMD_OPEN:    n_state = ST_CALC;
                        CMD_RELEASE: n_state = ST_CALC;
                        CMD_TICK: begin
                            if (w_tick_run) n_state = ST_CALC;
                        end
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL: n_state = ST_IDLE;
            ST_CALC: n_state = ST_STEP;
            ST_STEP: n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_taken) begin
                    n_state = i_stat.last_joint ? ST_IDLE : ST_CALC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_cmd_code)
                        CMD_LOAD:   o_cmd.load  = 1'b1;
                        CMD_SAMPLE: o_cmd.accum = 1'b1;
                        CMD_OPEN: begin
                            o_cmd.clr_closing = 1'b1;
                            o_cmd.start_run   = 1'b1;
                        end
                        CMD_CLOSE:   o_cmd.set_closing = 1'b1;
                        CMD_TICK:    o_cmd.start_run   = w_tick_run;
                        CMD_RELEASE: o_cmd.start_run   = 1'b1;
                        default:     o_cmd = '0;
                    endcase
                end
            end
            ST_EVAL: o_cmd.eval = 1'b1;
            ST_CALC: o_cmd.calc = 1'b1;
            ST_STEP: o_cmd.step = 1'b1;
            ST_OUT:  o_cmd.next_joint = i_stat.out_taken && !i_stat.last_joint;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/tggr_dp.sv
// ----------------------------------------------------------------------------
// tggr_dp
// Datapath: joint tables, pressure sums, grip flags, ramp step unit and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tggr_dp #(
    parameter int NUM_JOINTS = tggr_pkg::NUM_JOINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_wdata,
    input  wire tggr_pkg::t_in_item  i_item,
    input  wire tggr_pkg::t_dp_cmd   i_cmd,
    output tggr_pkg::t_dp_stat       o_stat,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output tggr_pkg::t_out_item      o_out_item
);
    import tggr_pkg::*;

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    logic signed [15:0] r_open_tab   [NUM_JOINTS];
    logic signed [15:0] r_closed_tab [NUM_JOINTS];
    logic signed [15:0] r_interp_tab [NUM_JOINTS];
    logic signed [15:0] r_opencmd_tab[NUM_JOINTS];

    logic [31:0]  r_thr;
    logic [31:0]  r_tsum;
    logic [31:0]  r_fsum;
    logic [7:0]   r_tcount;
    logic [7:0]   r_fcount;
    logic         r_tgrip;
    logic         r_fgrip;
    logic         r_closing;
    t_command     r_kind;
    logic [JW-1:0] r_joint;

    logic [STEP_W-1:0] r_q;
    logic              r_neg;
    logic              r_nz;
    logic [16:0]       r_ad;

    logic      r_out_valid;
    t_out_item r_out;

    // table reads at the current joint
    logic signed [15:0] w_open;
    logic signed [15:0] w_closed;
    logic signed [15:0] w_interp;
    logic signed [15:0] w_opencmd;

    assign w_open    = r_open_tab[r_joint];
    assign w_closed  = r_closed_tab[r_joint];
    assign w_interp  = r_interp_tab[r_joint];
    assign w_opencmd = r_opencmd_tab[r_joint];

    // accumulate
    logic        w_p_ok;
    logic        w_to_thumb;
    logic        w_to_finger;
    logic [32:0] w_tsum_add;
    logic [32:0] w_fsum_add;

    assign w_p_ok      = (i_item.pressure != INVALID_PRESSURE);
    assign w_to_thumb  = w_p_ok && (i_item.sensor_slot <= THUMB_LAST_SLOT);
    assign w_to_finger = w_p_ok && !w_to_thumb && (i_item.sensor_slot <= FINGER_LAST_SLOT);
    assign w_tsum_add  = {1'b0, r_tsum} + 33'(i_item.pressure);
    assign w_fsum_add  = {1'b0, r_fsum} + 33'(i_item.pressure);

    // frame end: average > threshold tested as sum > threshold * count
    logic [39:0] w_tlim;
    logic [39:0] w_flim;

    assign w_tlim = 40'(r_thr) * 40'(r_tcount);
    assign w_flim = 40'(r_thr) * 40'(r_fcount);

    // ramp step, first half: span, rounded /20, distance to target
    logic signed [16:0] w_span;
    logic [16:0]        w_mag;
    logic [16:0]        w_round;
    logic [34:0]        w_prod;
    logic signed [16:0] w_diff;
    logic [16:0]        w_ad;

    assign w_span  = {w_closed[15], w_closed} - {w_open[15], w_open};
    assign w_mag   = w_span[16] ? 17'(-w_span) : 17'(w_span);
    assign w_round = w_mag + ROUND_BIAS;
    assign w_prod  = 35'(w_round) * 35'(STEP_RECIP);
    assign w_diff  = {w_closed[15], w_closed} - {w_interp[15], w_interp};
    assign w_ad    = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);

    // ramp step, second half: move or snap
    logic [STEP_W-1:0]  w_q1;
    logic signed [16:0] w_step;
    logic signed [16:0] w_sum;
    logic signed [15:0] w_sat;
    logic signed [15:0] w_new;

    assign w_q1   = ((r_q == '0) && r_nz) ? STEP_W'(1) : r_q;
    assign w_step = r_neg ? -$signed(17'(w_q1)) : $signed(17'(w_q1));
    assign w_sum  = {w_interp[15], w_interp} + w_step;
    assign w_sat  = (w_sum[16] != w_sum[15]) ? (w_sum[16] ? 16'sh8000 : 16'sh7fff)
                                             : w_sum[15:0];
    assign w_new  = (r_ad > 17'(w_q1)) ? w_sat : w_closed;

    logic w_last;
    logic w_taken;

    assign w_last  = (r_joint == JW'(NUM_JOINTS - 1));
    assign w_taken = r_out_valid && i_out_ready;

    // tables, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_item.joint_index < 4'(NUM_JOINTS))) begin
            r_open_tab[i_item.joint_index[JW-1:0]]    <= i_item.open_position;
            r_closed_tab[i_item.joint_index[JW-1:0]]  <= i_item.closed_position;
            r_interp_tab[i_item.joint_index[JW-1:0]]  <= i_item.start_position;
            r_opencmd_tab[i_item.joint_index[JW-1:0]] <= i_item.open_command_position;
        end else if (i_cmd.step && (r_kind == CMD_TICK)) begin
            r_interp_tab[r_joint] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESH_RESET;
            r_tsum    <= '0;
            r_fsum    <= '0;
            r_tcount  <= '0;
            r_fcount  <= '0;
            r_tgrip   <= 1'b0;
            r_fgrip   <= 1'b0;
            r_closing <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.accum && w_to_thumb) begin
                r_tsum   <= w_tsum_add[32] ? '1 : w_tsum_add[31:0];
                r_tcount <= (r_tcount == 8'hff) ? r_tcount : r_tcount + 8'd1;
            end
            if (i_cmd.accum && w_to_finger) begin
                r_fsum   <= w_fsum_add[32] ? '1 : w_fsum_add[31:0];
                r_fcount <= (r_fcount == 8'hff) ? r_fcount : r_fcount + 8'd1;
            end
            if (i_cmd.eval) begin
                r_tgrip  <= (40'(r_tsum) > w_tlim);
                r_fgrip  <= (40'(r_fsum) > w_flim);
                r_tsum   <= '0;
                r_fsum   <= '0;
                r_tcount <= '0;
                r_fcount <= '0;
            end
            if (i_cmd.set_closing) begin
                r_closing <= 1'b1;
            end else if (i_cmd.clr_closing) begin
                r_closing <= 1'b0;
            end
        end
    end

    // run sequencing and the step unit pipeline register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint <= '0;
            r_kind  <= CMD_OPEN;
        end else if (i_cmd.start_run) begin
            r_joint <= '0;
            r_kind  <= t_command'(i_item.command);
        end else if (i_cmd.next_joint) begin
            r_joint <= r_joint + JW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_q   <= w_prod[STEP_SHIFT +: STEP_W];
            r_neg <= w_span[16];
            r_nz  <= (w_span != '0);
            r_ad  <= w_ad;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (w_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out.motor_id   <= 4'(r_joint);
            r_out.last_joint <= w_last;
            case (r_kind)
                CMD_OPEN: begin
                    r_out.mode_byte     <= {MODE_ACTIVE, 4'(r_joint)};
                    r_out.goal_position <= w_opencmd;
                    r_out.gains_enabled <= 1'b1;
                end
                CMD_TICK: begin
                    r_out.mode_byte     <= {MODE_ACTIVE, 4'(r_joint)};
                    r_out.goal_position <= w_new;
                    r_out.gains_enabled <= 1'b1;
                end
                default: begin
                    r_out.mode_byte     <= {MODE_TIMEOUT, 4'(r_joint)};
                    r_out.goal_position <= '0;
                    r_out.gains_enabled <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out;
    assign o_stat.closing      = r_closing;
    assign o_stat.both_gripped = r_tgrip && r_fgrip;
    assign o_stat.last_joint   = w_last;
    assign o_stat.out_taken    = w_taken;

endmodule

`default_nettype wire

>>> hdl/tactile_gated_grasp_ramp_core.sv
// Sequence: load, close, plain samples and unknown commands end in ST_IDLE; frame end adds ST_EVAL.
// Open, release and active ticks send NUM_JOINTS words, each joint passing ST_CALC
//   (table read and step multiply), ST_STEP (step update) and ST_OUT (output word).
// Throughput: one word at a time; the next input is taken after the last word.
// Reset (synchronous, i_rst_n low): sums, grip flags, closing clear, threshold
//   returns to 10000000; joint tables hold whatever was last loaded.
// ----------------------------------------------------------------------------
// tactile_gated_grasp_ramp_core
// Hand grip controller: tactile-gated grasp ramp over a per-joint table.
// ----------------------------------------------------------------------------
`default_nettype none

module tactile_gated_grasp_ramp_core #(
    parameter int NUM_JOINTS = tggr_pkg::NUM_JOINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tggr_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tggr_pkg::t_out_item      o_out_item
);
    import tggr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tggr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_in_item.command),
        .i_last_of_frame (i_in_item.last_of_frame),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    tggr_dp #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // no word pending while a new item can be taken
    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("word pending while accepting input");

    // last word of a run hands control back to the input side
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.last_joint) |=> o_in_ready)
        else $error("input not ready after last word");

    // the next joint is computed before its word appears
    a_gap_between_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_item.last_joint) |=>
            (!o_out_valid && !o_in_ready))
        else $error("word gap missing inside a run");

    // frame end holds off input while the threshold compare runs
    a_frame_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.last_of_frame &&
         (i_in_item.command == CMD_SAMPLE)) |=> !o_in_ready)
        else $error("frame end evaluation skipped");

endmodule

`default_nettype wire

>>> tb/tb_tactile_gated_grasp_ramp_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tactile_gated_grasp_ramp_core
// Self-checking bench for the grasp ramp core. Commands are fed through a
// valid/ready driver with random gaps. A behavioral model of the joint tables,
// pressure sums and ramp predicts every joint word, and a monitor with random
// back-pressure checks each word against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_tactile_gated_grasp_ramp_core;

    import tggr_pkg::*;

    localparam int JOINTS         = NUM_JOINTS_DEF;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 30;
    localparam int RANDOM_PHASES  = 5;
    localparam int RANDOM_PER_PH  = 12;
    localparam int SAT_SAMPLES    = 258;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;

    tactile_gated_grasp_ramp_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    t_in_item  cmd_queue[$];
    t_out_item joint_words_due[$];

    int err_count = 0;
    bit idle_on   = 1'b1;
    int tx_gap    = 0;
    int rx_stall  = 0;
    int hold_req  = 0;
    int hold_seen = 0;

    // grip model state
    logic [31:0]        m_threshold;
    logic signed [15:0] m_open[JOINTS];
    logic signed [15:0] m_closed[JOINTS];
    logic signed [15:0] m_interp[JOINTS];
    logic signed [15:0] m_open_cmd[JOINTS];
    logic [31:0]        m_thumb_sum, m_finger_sum;
    logic [7:0]         m_thumb_cnt, m_finger_cnt;
    bit                 m_thumb_grip, m_finger_grip, m_closing;

    function automatic int draw_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit group_holds(logic [31:0] sum, logic [7:0] cnt);
        return 64'(sum) > 64'(m_threshold) * 64'(cnt);
    endfunction

    function automatic void post_cmd(t_in_item w);
        cmd_queue.insert(cmd_queue.size(), w);
    endfunction

    function automatic void push_joint_word(int j, logic [3:0] mode,
                                            logic signed [15:0] target, bit gains);
        t_out_item o;
        o.motor_id      = 4'(j);
        o.mode_byte     = {mode, 4'(j)};
        o.goal_position = target;
        o.gains_enabled = gains;
        o.last_joint    = (j == JOINTS - 1);
        joint_words_due.insert(joint_words_due.size(), o);
    endfunction

    function automatic void apply_grip_command(t_in_item w);
        logic [32:0] s;
        int span, mag, q, stp, diff, nxt;
        case (w.command)
            CMD_LOAD: begin
                if (w.joint_index < JOINTS) begin
                    m_open[w.joint_index]     = w.open_position;
                    m_closed[w.joint_index]   = w.closed_position;
                    m_interp[w.joint_index]   = w.start_position;
                    m_open_cmd[w.joint_index] = w.open_command_position;
                end
            end
            CMD_SAMPLE: begin
                if (w.pressure != INVALID_PRESSURE) begin
                    if (w.sensor_slot <= THUMB_LAST_SLOT) begin
                        s = {1'b0, m_thumb_sum} + 33'(w.pressure);
                        m_thumb_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
                        if (m_thumb_cnt != 8'hFF) m_thumb_cnt++;
                    end else if (w.sensor_slot <= FINGER_LAST_SLOT) begin
                        s = {1'b0, m_finger_sum} + 33'(w.pressure);
                        m_finger_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
                        if (m_finger_cnt != 8'hFF) m_finger_cnt++;
                    end
                end
                if (w.last_of_frame) begin
                    m_thumb_grip  = group_holds(m_thumb_sum, m_thumb_cnt);
                    m_finger_grip = group_holds(m_finger_sum, m_finger_cnt);
                    m_thumb_sum   = '0;
                    m_thumb_cnt   = '0;
                    m_finger_sum  = '0;
                    m_finger_cnt  = '0;
                end
            end
            CMD_OPEN: begin
                m_closing = 1'b0;
                for (int j = 0; j < JOINTS; j++)
                    push_joint_word(j, MODE_ACTIVE, m_open_cmd[j], 1'b1);
            end
            CMD_CLOSE: m_closing = 1'b1;
            CMD_TICK: begin
                if (m_closing && !(m_thumb_grip && m_finger_grip)) begin
                    for (int j = 0; j < JOINTS; j++) begin
                        span = int'(m_closed[j]) - int'(m_open[j]);
                        mag  = (span < 0) ? -span : span;
                        // nearest twentieth of the span, never zero for a nonzero span
                        q = (mag + 10) / 20;
                        if (q == 0 && mag != 0) q = 1;
                        stp  = (span < 0) ? -q : q;
                        diff = int'(m_closed[j]) - int'(m_interp[j]);
                        if (diff < 0) diff = -diff;
                        if (diff > q) begin
                            nxt = int'(m_interp[j]) + stp;
                            if (nxt > 32767) nxt = 32767;
                            if (nxt < -32768) nxt = -32768;
                            m_interp[j] = 16'(nxt);
                        end else begin
                            m_interp[j] = m_closed[j];
                        end
                        push_joint_word(j, MODE_ACTIVE, m_interp[j], 1'b1);
                    end
                end
            end
            CMD_RELEASE: begin
                for (int j = 0; j < JOINTS; j++)
                    push_joint_word(j, MODE_TIMEOUT, 16'sd0, 1'b0);
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item scrambled_item(logic [2:0] cmd);
        t_in_item w;
        w.command               = cmd;
        w.joint_index           = 4'($urandom);
        w.open_position         = 16'($urandom);
        w.closed_position       = 16'($urandom);
        w.start_position        = 16'($urandom);
        w.open_command_position = 16'($urandom);
        w.sensor_slot           = 4'($urandom);
        w.pressure              = 24'($urandom);
        w.last_of_frame         = 1'($urandom);
        return w;
    endfunction

    function automatic t_in_item load_item(int idx, int op, int cl, int st, int oc);
        t_in_item w;
        w = scrambled_item(CMD_LOAD);
        w.joint_index           = 4'(idx);
        w.open_position         = 16'(op);
        w.closed_position       = 16'(cl);
        w.start_position        = 16'(st);
        w.open_command_position = 16'(oc);
        return w;
    endfunction

    function automatic t_in_item sample_item(int slot, logic [23:0] p, bit last);
        t_in_item w;
        w = scrambled_item(CMD_SAMPLE);
        w.sensor_slot   = 4'(slot);
        w.pressure      = p;
        w.last_of_frame = last;
        return w;
    endfunction

    function automatic t_in_item random_grip_item();
        t_in_item w;
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            w = scrambled_item(CMD_SAMPLE);
            w.sensor_slot = ($urandom_range(9) < 7) ? 4'($urandom_range(8))
                                                    : 4'($urandom_range(9, 15));
            r = $urandom_range(9);
            if (r == 0) w.pressure = INVALID_PRESSURE;
            else if (r == 1) w.pressure = 24'hFFFFFF;
            else if (r < 6 && m_threshold <= 32'h7FFFFF)
                w.pressure = 24'($urandom_range(0, 2 * m_threshold));
            w.last_of_frame = ($urandom_range(4) == 0);
        end else if (r < 65) begin
            w = scrambled_item(CMD_TICK);
        end else if (r < 72) begin
            w = scrambled_item(CMD_CLOSE);
        end else if (r < 77) begin
            w = scrambled_item(CMD_OPEN);
        end else if (r < 82) begin
            w = scrambled_item(CMD_RELEASE);
        end else if (r < 94) begin
            w = scrambled_item(CMD_LOAD);
            if ($urandom_range(9) < 8) w.joint_index = 4'($urandom_range(JOINTS - 1));
            // short spans so the ramp reaches the closed end within a few ticks
            if ($urandom_range(1)) begin
                w.closed_position = 16'(int'(w.open_position) + $urandom_range(400) - 200);
                if ($urandom_range(1)) w.start_position = w.open_position;
            end
        end else begin
            w = scrambled_item($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B);
        end
        return w;
    endfunction

    // sender
    always @(posedge i_clk) begin : drive_proc
        t_in_item nxt_item;
        logic     nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_item  = i_in_item;
            if (i_in_valid && o_in_ready) begin
                apply_grip_command(i_in_item);
                nxt_valid = 1'b0;
                tx_gap    = draw_gap();
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (cmd_queue.size() != 0) begin
                    nxt_item  = cmd_queue.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            i_in_valid <= nxt_valid;
            i_in_item  <= nxt_item;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : watch_proc
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                if (joint_words_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"unexpected word: id %0d mode %02h target %0d",
                                  " gains %0b last %0b"},
                                 got.motor_id, got.mode_byte, got.goal_position,
                                 got.gains_enabled, got.last_joint);
                end else begin
                    want = joint_words_due.pop_front();
                    if (got.motor_id !== want.motor_id ||
                        got.mode_byte !== want.mode_byte ||
                        got.goal_position !== want.goal_position ||
                        got.gains_enabled !== want.gains_enabled ||
                        got.last_joint !== want.last_joint) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch: exp id %0d mode %02h target %0d gains %0b",
                                      " last %0b, got id %0d mode %02h target %0d gains %0b",
                                      " last %0b"},
                                     want.motor_id, want.mode_byte, want.goal_position,
                                     want.gains_enabled, want.last_joint,
                                     got.motor_id, got.mode_byte, got.goal_position,
                                     got.gains_enabled, got.last_joint);
                    end
                end
                rx_stall = draw_gap();
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_stall  = RX_HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained(input int settle);
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || joint_words_due.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        m_threshold = v;
        @(negedge i_clk);
    endtask

    initial begin
        m_threshold   = THRESH_RESET;
        m_thumb_sum   = '0;
        m_finger_sum  = '0;
        m_thumb_cnt   = '0;
        m_finger_cnt  = '0;
        m_thumb_grip  = 1'b0;
        m_finger_grip = 1'b0;
        m_closing     = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: nothing may read the joint tables before all of them are loaded
        post_cmd(scrambled_item(CMD_RELEASE));
        post_cmd(scrambled_item(CMD_TICK));
        post_cmd(scrambled_item(CMD_SPARE_A));
        post_cmd(scrambled_item(CMD_SPARE_B));
        post_cmd(load_item(15, 1, 2, 3, 4));
        post_cmd(load_item(JOINTS, 5, 6, 7, 8));
        post_cmd(load_item(0, -32768, 32767, -32768, 32767));
        post_cmd(load_item(1, 32767, -32768, 32767, -32768));
        post_cmd(load_item(2, 100, 100, -5, 0));
        post_cmd(load_item(3, 0, 7, 0, 1));
        // start beyond the closed end: the ramp runs away and saturates
        post_cmd(load_item(4, -32768, 0, 32767, -1));
        // span of thirty rounds its half-way twentieth away from zero
        post_cmd(load_item(5, 0, -30, 0, 12));
        post_cmd(load_item(6, $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535)));
        post_cmd(scrambled_item(CMD_OPEN));
        post_cmd(scrambled_item(CMD_CLOSE));
        post_cmd(sample_item(0, INVALID_PRESSURE, 1'b0));
        post_cmd(sample_item(1, 24'hFFFFFF, 1'b0));
        post_cmd(sample_item(8, 24'd12000000, 1'b0));
        post_cmd(sample_item(12, 24'd5, 1'b1));
        post_cmd(scrambled_item(CMD_TICK));
        post_cmd(sample_item(9, 24'd10000000, 1'b1));
        post_cmd(scrambled_item(CMD_TICK));
        post_cmd(scrambled_item(CMD_TICK));
        post_cmd(scrambled_item(CMD_RELEASE));
        post_cmd(scrambled_item(CMD_TICK));
        wait_drained(SETTLE_CYCLES);

        // one long frame drives the thumb sum and count into saturation;
        // the threshold makes threshold * 255 equal the saturated sum
        write_threshold(32'd16843009);
        for (int n = 0; n < SAT_SAMPLES; n++)
            post_cmd(sample_item(n % 2, 24'hFFFFFF, n == SAT_SAMPLES - 1));
        post_cmd(scrambled_item(CMD_CLOSE));
        post_cmd(scrambled_item(CMD_TICK));
        wait_drained(SETTLE_CYCLES);

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            case (k)
                0: write_threshold(32'd0);
                1: write_threshold(32'hFFFF_FFFF);
                2: write_threshold(THRESH_RESET);
                3: write_threshold(32'($urandom_range(24'hFFFFFF)));
                default: write_threshold($urandom);
            endcase
            idle_on = (k != 2);
            for (int n = 0; n < RANDOM_PER_PH; n++)
                post_cmd(random_grip_item());
            wait_drained(SETTLE_CYCLES);

            if (k == 1) begin
                // receiver stops for a long stretch while commands keep coming
                hold_req++;
                post_cmd(scrambled_item(CMD_CLOSE));
                post_cmd(scrambled_item(CMD_RELEASE));
                post_cmd(scrambled_item(CMD_OPEN));
                post_cmd(scrambled_item(CMD_RELEASE));
                post_cmd(scrambled_item(CMD_CLOSE));
                post_cmd(scrambled_item(CMD_TICK));
                post_cmd(scrambled_item(CMD_TICK));
                post_cmd(scrambled_item(CMD_RELEASE));
                wait_drained(SETTLE_CYCLES);
            end
        end

        wait_drained(SETTLE_CYCLES + 10);
        err_count += joint_words_due.size();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hdl/tggr_pkg.sv
hdl/tggr_ctrl.sv
hdl/tggr_dp.sv
hdl/tactile_gated_grasp_ramp_core.sv
tb/tb_tactile_gated_grasp_ramp_core.sv
